// ===== rtl/core/sos_pkg.sv =====
// Shared constants, types and command/status structs of the segment scatter block.
package sos_pkg;

    localparam int MAX_SEG_COLS  = 1024;
    localparam int MAX_SEG_ROWS  = 1024;
    localparam int MAX_DEST_COLS = 4096;
    localparam int MAX_SEGMENTS  = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_SEG_COLS  = 2'd0;
    localparam logic [1:0] CFG_SEG_ROWS  = 2'd1;
    localparam logic [1:0] CFG_DEST_COLS = 2'd2;

    localparam int CNT_W  = $clog2(MAX_SEG_COLS);      // column / row counters
    localparam int COLS_W = 11;                        // seg_cols, seg_rows
    localparam int PITCH_W = 13;                       // dest_cols
    localparam int OFF_W  = 13;                        // signed offsets
    localparam int POS_W  = OFF_W + 1;                 // signed destination position
    localparam int BASE_W = 17;                        // segment * seg_rows + row
    localparam int DIV_STEPS = OFF_W;

    typedef struct packed {
        logic              first;
        logic [31:0]       pixel_value;
        logic [5:0]        segment;
        logic [11:0]       dest_col_start;
        logic [11:0]       dest_row_start;
        logic signed [1:0] col_step_per_col;
        logic signed [1:0] row_step_per_col;
        logic signed [1:0] col_step_per_row;
        logic signed [1:0] row_step_per_row;
    } pix_in_t;

    typedef struct packed {
        logic [31:0] out_value;
        logic [23:0] dest_index;
        logic [25:0] source_index;
        logic        in_range;
        logic        last;
    } pix_out_t;

    typedef struct packed {
        logic capture;
        logic rem_start;
        logic rem_wb;
        logic addr1;
        logic addr2;
        logic finish;
    } sos_cmd_t;

    typedef struct packed {
        logic need_rem;
        logic rem_done;
        logic out_free;
    } sos_sts_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_REM   = 6'b000010,
        S_DIV   = 6'b000100,
        S_ADDR1 = 6'b001000,
        S_ADDR2 = 6'b010000,
        S_DONE  = 6'b100000
    } sos_state_t;

endpackage

// ===== rtl/core/sos_rem.sv =====
// Two-lane restoring remainder unit: offset magnitudes modulo seg_cols, one bit a cycle.
module sos_rem
    import sos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [OFF_W-1:0]   col_mag,
    input  logic [OFF_W-1:0]   row_mag,
    input  logic [COLS_W-1:0]  divisor,
    output logic               done,
    output logic [CNT_W-1:0]   col_rem,
    output logic [CNT_W-1:0]   row_rem
);

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [OFF_W-1:0]   cmag_reg, cmag_next, rmag_reg, rmag_next;
    logic [CNT_W-1:0]   crem_reg, crem_next, rrem_reg, rrem_next;
    logic [COLS_W-1:0]  ct, rt;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        cmag_next = cmag_reg;
        rmag_next = rmag_reg;
        crem_next = crem_reg;
        rrem_next = rrem_reg;
        ct = {crem_reg, cmag_reg[OFF_W-1]};
        rt = {rrem_reg, rmag_reg[OFF_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            cmag_next = col_mag;
            rmag_next = row_mag;
            crem_next = '0;
            rrem_next = '0;
        end
        else if (busy_reg)
        begin
            cmag_next = {cmag_reg[OFF_W-2:0], 1'b0};
            rmag_next = {rmag_reg[OFF_W-2:0], 1'b0};
            crem_next = (ct >= divisor) ? CNT_W'(ct - divisor) : CNT_W'(ct);
            rrem_next = (rt >= divisor) ? CNT_W'(rt - divisor) : CNT_W'(rt);
            cnt_next  = STEP_W'(cnt_reg + 1'b1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmag_reg <= cmag_next;
        rmag_reg <= rmag_next;
        crem_reg <= crem_next;
        rrem_reg <= rrem_next;
    end

    assign done    = done_reg;
    assign col_rem = crem_reg;
    assign row_rem = rrem_reg;

endmodule

// ===== rtl/core/sos_ctrl.sv =====
// Controller: sequences capture, remainder, address stages and result hand-off of one item.
module sos_ctrl
    import sos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sos_sts_t sts,
    output sos_cmd_t cmd
);

    sos_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_REM;
                end
            end
            S_REM:
            begin
                if (sts.need_rem)
                begin
                    cmd.rem_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_ADDR1;
                end
            end
            S_DIV:
            begin
                if (sts.rem_done)
                begin
                    cmd.rem_wb = 1'b1;
                    state_next = S_ADDR1;
                end
            end
            S_ADDR1:
            begin
                cmd.addr1  = 1'b1;
                state_next = S_ADDR2;
            end
            S_ADDR2:
            begin
                cmd.addr2  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/core/sos_datapath.sv =====
// Datapath: segment state, offset remainder, address multipliers and result register.
module sos_datapath
    import sos_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  sos_cmd_t           cmd,
    output sos_sts_t           sts,
    input  pix_in_t            pix_in,
    input  logic [COLS_W-1:0]  cols,
    input  logic [COLS_W-1:0]  rows,
    input  logic [PITCH_W-1:0] pitch,
    output logic               out_valid,
    input  logic               out_ready,
    output pix_out_t           pix_out
);

    // segment state
    logic [31:0]             pix_reg;
    logic [11:0]             start_col_reg, start_row_reg;
    logic signed [1:0]       step_reg [4];
    logic signed [OFF_W-1:0] col_off_reg, row_off_reg;
    logic [CNT_W-1:0]        col_cnt_reg, row_cnt_reg;
    logic [BASE_W-1:0]       src_base_reg;

    // address stages
    logic signed [POS_W-1:0] dcol_reg, drow_reg;
    logic [BASE_W-1:0]       src_row_reg;
    logic [26:0]             prod_reg;
    logic [BASE_W+COLS_W-1:0] sprod_reg;
    logic                    okpre_reg;

    // result register
    pix_out_t                out_reg;
    logic                    out_valid_reg, out_valid_next;

    logic [OFF_W-1:0]        cmag, rmag;
    logic                    rem_done;
    logic [CNT_W-1:0]        col_rem, row_rem;
    logic                    row_end, seg_end;
    logic [26:0]             dsum;
    logic                    ok;
    logic signed [OFF_W-1:0] col_off_step, row_off_step;

    assign cmag = col_off_reg[OFF_W-1] ? OFF_W'(-col_off_reg) : OFF_W'(col_off_reg);
    assign rmag = row_off_reg[OFF_W-1] ? OFF_W'(-row_off_reg) : OFF_W'(row_off_reg);

    sos_rem u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.rem_start),
        .col_mag (cmag),
        .row_mag (rmag),
        .divisor (cols),
        .done    (rem_done),
        .col_rem (col_rem),
        .row_rem (row_rem)
    );

    // both magnitudes already below seg_cols: remainder leaves them as they are
    assign sts.need_rem = (col_cnt_reg == '0) &&
                          !((COLS_W'(cmag) < cols) && (COLS_W'(rmag) < cols) &&
                            (cmag[OFF_W-1:COLS_W] == '0) && (rmag[OFF_W-1:COLS_W] == '0));
    assign sts.rem_done = rem_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign row_end = (COLS_W'(col_cnt_reg) + 1'b1) >= cols;
    assign seg_end = row_end && ((COLS_W'(row_cnt_reg) + 1'b1) >= rows);

    assign dsum = prod_reg + 27'(dcol_reg[PITCH_W-1:0]);
    assign ok   = okpre_reg && (dsum[26:24] == '0);

    assign col_off_step = col_off_reg + OFF_W'(step_reg[0])
                        + (row_end ? OFF_W'(step_reg[2]) : OFF_W'(0));
    assign row_off_step = row_off_reg + OFF_W'(step_reg[1])
                        + (row_end ? OFF_W'(step_reg[3]) : OFF_W'(0));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pix_in.pixel_value;
        end
        if (cmd.addr1)
        begin
            dcol_reg    <= POS_W'(start_col_reg) + POS_W'(col_off_reg);
            drow_reg    <= POS_W'(start_row_reg) + POS_W'(row_off_reg);
            src_row_reg <= src_base_reg + BASE_W'(row_cnt_reg);
        end
        if (cmd.addr2)
        begin
            prod_reg  <= 27'(drow_reg[PITCH_W-1:0]) * 27'(pitch);
            sprod_reg <= src_row_reg * cols;
            okpre_reg <= !dcol_reg[POS_W-1] && !drow_reg[POS_W-1] &&
                         (dcol_reg[PITCH_W-1:0] < pitch) && !dcol_reg[PITCH_W];
        end
        if (cmd.finish)
        begin
            out_reg.out_value    <= pix_reg;
            out_reg.dest_index   <= ok ? dsum[23:0] : 24'd0;
            out_reg.source_index <= 26'(sprod_reg + 28'(col_cnt_reg));
            out_reg.in_range     <= ok;
            out_reg.last         <= seg_end;
        end
    end

    // latched segment fields: zero until an item starts a segment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_col_reg <= '0;
            start_row_reg <= '0;
            step_reg[0]   <= '0;
            step_reg[1]   <= '0;
            step_reg[2]   <= '0;
            step_reg[3]   <= '0;
            src_base_reg  <= '0;
        end
        else if (cmd.capture && pix_in.first)
        begin
            start_col_reg <= pix_in.dest_col_start;
            start_row_reg <= pix_in.dest_row_start;
            step_reg[0]   <= pix_in.col_step_per_col;
            step_reg[1]   <= pix_in.row_step_per_col;
            step_reg[2]   <= pix_in.col_step_per_row;
            step_reg[3]   <= pix_in.row_step_per_row;
            src_base_reg  <= BASE_W'(pix_in.segment) * BASE_W'(rows);
        end
    end

    // offsets and counters cleared at reset, by a first item and at a segment's last pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_off_reg <= '0;
            row_off_reg <= '0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cmd.capture && pix_in.first)
        begin
            col_off_reg <= '0;
            row_off_reg <= '0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (cmd.rem_wb)
        begin
            col_off_reg <= col_off_reg[OFF_W-1] ? OFF_W'(-OFF_W'(col_rem)) : OFF_W'(col_rem);
            row_off_reg <= row_off_reg[OFF_W-1] ? OFF_W'(-OFF_W'(row_rem)) : OFF_W'(row_rem);
        end
        else if (cmd.finish)
        begin
            if (seg_end)
            begin
                col_off_reg <= '0;
                row_off_reg <= '0;
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end
            else
            begin
                col_off_reg <= col_off_step;
                row_off_reg <= row_off_step;
                if (row_end)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= CNT_W'(row_cnt_reg + 1'b1);
                end
                else
                begin
                    col_cnt_reg <= CNT_W'(col_cnt_reg + 1'b1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign pix_out   = out_reg;

endmodule

// ===== rtl/core/segment_orientation_scatter.sv =====
// Top level of the segment scatter address generator: ports, configuration registers, wiring.
//
// Pixels of one source segment stream in raster order on s_axis; each item gives one
// result on m_axis carrying the pixel word, its linear destination index in the wider
// image (zero and in_range low when the position falls outside) and its linear source
// index. An item with tuser set starts a segment and latches segment number, start
// column/row and the four steps; m_axis_tlast marks the final pixel of the segment.
// An item occupies the block through capture, remainder check, position add, the two
// address multipliers and result load, and no new item is taken before it is done.
// On the first pixel of a source row, when either offset magnitude is at or above
// seg_cols, the two-lane bit-serial remainder unit runs after the remainder check.
// A result blocked on m_axis holds the next one in its load step.
// The result sits in an output register, so the next item is taken while it waits.
// seg_cols and seg_rows are used clamped to 1..1024, dest_cols to 1..4096.
// Configuration is written through cfg_*; writes to an index beyond dest_cols are ignored.
module segment_orientation_scatter
    import sos_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] pixel_value, [37:32] segment, [49:38] dest_col_start,
    // [61:50] dest_row_start, [63:62] col_step_per_col, [65:64] row_step_per_col,
    // [67:66] col_step_per_row, [69:68] row_step_per_row, [71:70] zero
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,      // first
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] out_value, [55:32] dest_index, [81:56] source_index, [87:82] zero
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tuser,      // in_range
    output logic        m_axis_tlast       // last
);

    logic [COLS_W-1:0]  seg_cols_reg, seg_rows_reg;
    logic [PITCH_W-1:0] dest_cols_reg;
    logic [COLS_W-1:0]  cols_eff, rows_eff;
    logic [PITCH_W-1:0] pitch_eff;

    pix_in_t  pix_in;
    pix_out_t pix_out;
    sos_cmd_t cmd;
    sos_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_cols_reg  <= COLS_W'(388);
            seg_rows_reg  <= COLS_W'(185);
            dest_cols_reg <= PITCH_W'(1516);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SEG_COLS:  seg_cols_reg  <= cfg_data[COLS_W-1:0];
                CFG_SEG_ROWS:  seg_rows_reg  <= cfg_data[COLS_W-1:0];
                CFG_DEST_COLS: dest_cols_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // clamp to the supported ranges
    assign cols_eff  = (seg_cols_reg == '0) ? COLS_W'(1) :
                       (seg_cols_reg > COLS_W'(MAX_SEG_COLS)) ? COLS_W'(MAX_SEG_COLS)
                                                              : seg_cols_reg;
    assign rows_eff  = (seg_rows_reg == '0) ? COLS_W'(1) :
                       (seg_rows_reg > COLS_W'(MAX_SEG_ROWS)) ? COLS_W'(MAX_SEG_ROWS)
                                                              : seg_rows_reg;
    assign pitch_eff = (dest_cols_reg == '0) ? PITCH_W'(1) :
                       (dest_cols_reg > PITCH_W'(MAX_DEST_COLS)) ? PITCH_W'(MAX_DEST_COLS)
                                                                 : dest_cols_reg;

    // unpack the input item
    assign pix_in.first            = s_axis_tuser;
    assign pix_in.pixel_value      = s_axis_tdata[31:0];
    assign pix_in.segment          = s_axis_tdata[37:32];
    assign pix_in.dest_col_start   = s_axis_tdata[49:38];
    assign pix_in.dest_row_start   = s_axis_tdata[61:50];
    assign pix_in.col_step_per_col = s_axis_tdata[63:62];
    assign pix_in.row_step_per_col = s_axis_tdata[65:64];
    assign pix_in.col_step_per_row = s_axis_tdata[67:66];
    assign pix_in.row_step_per_row = s_axis_tdata[69:68];

    sos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sos_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .pix_in    (pix_in),
        .cols      (cols_eff),
        .rows      (rows_eff),
        .pitch     (pitch_eff),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .pix_out   (pix_out)
    );

    // pack the result item
    assign m_axis_tdata = {6'd0, pix_out.source_index, pix_out.dest_index, pix_out.out_value};
    assign m_axis_tuser = pix_out.in_range;
    assign m_axis_tlast = pix_out.last;

endmodule

// ===== tb/sv/segment_orientation_scatter_test.sv =====
// Self-checking testbench of the segment scatter address generator.
module segment_orientation_scatter_test
    import sos_pkg::*;
();

    // register index the block ignores; written once to show it has no effect
    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         LIMIT_CYCLES  = 400_000;
    localparam int         SETTLE_CYCLES = 25;    // beyond the slowest pixel
    localparam int         MODE_ITEMS    = 285;   // minimum random items per idling mode
    localparam int         PHASE_ITEMS   = 72;    // random items per register setting

    // ------------------------------------------------------------------
    // Expected pixel writes: own copy of registers and segment state,
    // advanced once per accepted input item.
    // ------------------------------------------------------------------
    class scatter_tracker;
        logic [10:0] seg_cols_q;
        logic [10:0] seg_rows_q;
        logic [12:0] dest_cols_q;
        int          start_col;
        int          start_row;
        int          steps[4];    // col per col, row per col, col per row, row per row
        int          col_off;
        int          row_off;
        int          col_cnt;
        int          row_cnt;
        int          src_base;
        pix_out_t    pending[$];
        int          errors;
        int          checked;
        int          lasts;
        int          hits;

        function new();
            seg_cols_q  = 11'd388;
            seg_rows_q  = 11'd185;
            dest_cols_q = 13'd1516;
            start_col   = 0;
            start_row   = 0;
            foreach (steps[i]) steps[i] = 0;
            col_off     = 0;
            row_off     = 0;
            col_cnt     = 0;
            row_cnt     = 0;
            src_base    = 0;
            errors      = 0;
            checked     = 0;
            lasts       = 0;
            hits        = 0;
        endfunction

        function int bounded(int v, int hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                CFG_SEG_COLS:  seg_cols_q  = val[10:0];
                CFG_SEG_ROWS:  seg_rows_q  = val[10:0];
                CFG_DEST_COLS: dest_cols_q = val;
                default: ;
            endcase
        endfunction

        function void note_pixel(pix_in_t p);
            int       cols;
            int       rows;
            int       pitch;
            int       dcol;
            int       drow;
            bit       ok;
            bit       row_end;
            bit       seg_end;
            longint   didx;
            longint   sidx;
            pix_out_t e;
            cols  = bounded(int'(seg_cols_q), MAX_SEG_COLS);
            rows  = bounded(int'(seg_rows_q), MAX_SEG_ROWS);
            pitch = bounded(int'(dest_cols_q), MAX_DEST_COLS);
            if (p.first)
            begin
                src_base  = (int'(p.segment) % MAX_SEGMENTS) * rows;
                start_col = int'(p.dest_col_start);
                start_row = int'(p.dest_row_start);
                steps[0]  = int'($signed(p.col_step_per_col));
                steps[1]  = int'($signed(p.row_step_per_col));
                steps[2]  = int'($signed(p.col_step_per_row));
                steps[3]  = int'($signed(p.row_step_per_row));
                col_off   = 0;
                row_off   = 0;
                col_cnt   = 0;
                row_cnt   = 0;
            end
            // offsets wrap by the segment width at each row start, sign kept
            if (col_cnt == 0)
            begin
                col_off = col_off % cols;
                row_off = row_off % cols;
            end
            dcol = start_col + col_off;
            drow = start_row + row_off;
            ok   = dcol >= 0 && dcol < pitch && drow >= 0;
            didx = 0;
            if (ok)
            begin
                didx = longint'(drow) * pitch + dcol;
                if (didx >= (longint'(1) << 24))
                begin
                    ok   = 1'b0;
                    didx = 0;
                end
            end
            sidx    = (longint'(src_base) + row_cnt) * cols + col_cnt;
            row_end = col_cnt + 1 >= cols;
            seg_end = row_end && (row_cnt + 1 >= rows);
            e.out_value    = p.pixel_value;
            e.dest_index   = didx[23:0];
            e.source_index = sidx[25:0];
            e.in_range     = ok;
            e.last         = seg_end;
            pending.push_back(e);
            if (seg_end)
            begin
                col_off = 0;
                row_off = 0;
                col_cnt = 0;
                row_cnt = 0;
            end
            else
            begin
                col_off += steps[0];
                row_off += steps[1];
                if (row_end)
                begin
                    col_off += steps[2];
                    row_off += steps[3];
                    col_cnt = 0;
                    row_cnt++;
                end
                else
                    col_cnt++;
            end
        endfunction

        function void compare(string field, longint want, longint got_v);
            if (want != got_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got_v);
            end
        endfunction

        function void check_result(pix_out_t got);
            pix_out_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: pixel write with none expected, got %h", $time, got);
                return;
            end
            e = pending.pop_front();
            checked++;
            lasts += int'(got.last);
            hits  += int'(got.in_range);
            compare("out_value", longint'(e.out_value), longint'(got.out_value));
            compare("dest_index", longint'(e.dest_index), longint'(got.dest_index));
            compare("source_index", longint'(e.source_index), longint'(got.source_index));
            compare("in_range", longint'(e.in_range), longint'(got.in_range));
            compare("last", longint'(e.last), longint'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = '0;
    logic [12:0] cfg_data       = '0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata   = '0;
    logic        s_axis_tuser   = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    scatter_tracker sb;
    int             send_idle_pct = 8;
    int             recv_idle_pct = 68;
    int             cycles        = 0;
    int             pixels_in     = 0;
    int             reg_writes    = 0;

    segment_orientation_scatter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Monitors: everything is sampled on the rising edge, where all
    // testbench drives (falling edge) are long settled.
    always @(posedge clk)
    begin
        pix_in_t  pin;
        pix_out_t pout;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
            $display("[FAIL] regression broken");
            $finish;
        end
        if (cfg_valid && cfg_ready)
        begin
            sb.set_reg(cfg_index, cfg_data);
            reg_writes++;
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            pin.first            = s_axis_tuser;
            pin.pixel_value      = s_axis_tdata[31:0];
            pin.segment          = s_axis_tdata[37:32];
            pin.dest_col_start   = s_axis_tdata[49:38];
            pin.dest_row_start   = s_axis_tdata[61:50];
            pin.col_step_per_col = s_axis_tdata[63:62];
            pin.row_step_per_col = s_axis_tdata[65:64];
            pin.col_step_per_row = s_axis_tdata[67:66];
            pin.row_step_per_row = s_axis_tdata[69:68];
            sb.note_pixel(pin);
            pixels_in++;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            pout.out_value    = m_axis_tdata[31:0];
            pout.dest_index   = m_axis_tdata[55:32];
            pout.source_index = m_axis_tdata[81:56];
            pout.in_range     = m_axis_tuser;
            pout.last         = m_axis_tlast;
            sb.check_result(pout);
        end
    end

    // Offers one pixel and returns on the falling edge after acceptance.
    // tvalid is left high so back-to-back pixels need no second assignment
    // in the same step; a gap lowers it.
    task automatic send_pixel(pix_in_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= p.first;
        s_axis_tdata  <= {2'b00, p.row_step_per_row, p.col_step_per_row,
                          p.row_step_per_col, p.col_step_per_col, p.dest_row_start,
                          p.dest_col_start, p.segment, p.pixel_value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_fields(bit first, logic [31:0] value, logic [5:0] seg,
                               logic [11:0] col, logic [11:0] row, logic [1:0] cpc,
                               logic [1:0] rpc, logic [1:0] cpr, logic [1:0] rpr);
        pix_in_t p;
        p.first            = first;
        p.pixel_value      = value;
        p.segment          = seg;
        p.dest_col_start   = col;
        p.dest_row_start   = row;
        p.col_step_per_col = cpc;
        p.row_step_per_col = rpc;
        p.col_step_per_row = cpr;
        p.row_step_per_row = rpr;
        send_pixel(p);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers change only once the block has gone quiet: every expected
    // write back, then a settle time past the slowest pixel.
    task automatic write_config(logic [12:0] cols, logic [12:0] rows, logic [12:0] pitch,
                                bit poke_spare);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        put_reg(CFG_SEG_COLS, cols);
        put_reg(CFG_SEG_ROWS, rows);
        put_reg(CFG_DEST_COLS, pitch);
        if (poke_spare)
            put_reg(CFG_SPARE, 13'h0005);
        cfg_valid <= 1'b0;
    endtask

    // Start position near the image origin half the time, so that some
    // pixels land inside it; anywhere in the 12-bit range otherwise.
    function automatic pix_in_t random_pixel(bit first, int pitch);
        pix_in_t p;
        p.first       = first;
        p.pixel_value = $urandom;
        p.segment     = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 1))
        begin
            p.dest_col_start = 12'($urandom_range(0, pitch - 1));
            p.dest_row_start = 12'($urandom_range(0, 15));
        end
        else
        begin
            p.dest_col_start = 12'($urandom);
            p.dest_row_start = 12'($urandom);
        end
        p.col_step_per_col = 2'($urandom_range(0, 3));
        p.row_step_per_col = 2'($urandom_range(0, 3));
        p.col_step_per_row = 2'($urandom_range(0, 3));
        p.row_step_per_row = 2'($urandom_range(0, 3));
        return p;
    endfunction

    // Mostly whole segments (first pixel, then the rest in raster order);
    // some run past the last pixel, some are abandoned, some items are noise.
    // A segment over 120 pixels or over the rest of the quota is cut short.
    task automatic random_burst(int quota);
        int sent;
        int len;
        int roll;
        int cols_e;
        int rows_e;
        int pitch_e;
        sent    = 0;
        cols_e  = sb.bounded(int'(sb.seg_cols_q), MAX_SEG_COLS);
        rows_e  = sb.bounded(int'(sb.seg_rows_q), MAX_SEG_ROWS);
        pitch_e = sb.bounded(int'(sb.dest_cols_q), MAX_DEST_COLS);
        while (sent < quota)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                len = cols_e * rows_e;
                if (roll < 10)
                    len += $urandom_range(1, 3);
                else if (roll < 20)
                    len = $urandom_range(1, len);
                if (len > 120)
                    len = $urandom_range(20, 120);
                if (len > quota - sent)
                    len = quota - sent;
                for (int k = 0; k < len; k++)
                    send_pixel(random_pixel(k == 0, pitch_e));
                sent += len;
            end
            else
            begin
                send_pixel(random_pixel($urandom_range(0, 1), pitch_e));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [12:0] c;
        logic [12:0] r;
        logic [12:0] d;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        // no first pixel yet: latched values are the reset zeros
        send_fields(1'b0, 32'h0000_0000, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);
        send_fields(1'b0, 32'hFFFF_FFFF, 6'd63, 12'hFFF, 12'hFFF, 2'b11, 2'b11, 2'b11, 2'b11);

        // 2x2 segment at the far corner, a step of -2 among the four,
        // then two pixels past the last one to restart the same segment
        write_config(13'd2, 13'd2, 13'd4096, 1'b1);
        send_fields(1'b1, 32'hA5A5_5A5A, 6'd63, 12'hFFF, 12'hFFF, 2'b01, 2'b10, 2'b11, 2'b00);
        repeat (5)
            send_fields(1'b0, $urandom, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);
        send_fields(1'b1, 32'h1234_5678, 6'd0, 12'd0, 12'd0, 2'b00, 2'b01, 2'b10, 2'b11);
        repeat (3)
            send_fields(1'b0, $urandom, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);

        // out-of-range registers (clamped to 1, 1024, 1) changed after a complete segment
        write_config(13'd0, 13'd2047, 13'd0, 1'b0);
        repeat (3)
            send_fields(1'b0, $urandom, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);
        send_fields(1'b1, $urandom, 6'd5, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);
        send_fields(1'b0, $urandom, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);

        // widest segment and pitch: the corner pixel is the top index,
        // one row down crosses the 24-bit limit; then negative positions
        write_config(13'h1FFF, 13'd1, 13'h1FFF, 1'b0);
        send_fields(1'b1, $urandom, 6'd1, 12'hFFF, 12'hFFF, 2'b00, 2'b01, 2'b00, 2'b00);
        repeat (2)
            send_fields(1'b0, $urandom, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);
        send_fields(1'b1, $urandom, 6'd2, 12'd0, 12'd0, 2'b10, 2'b11, 2'b00, 2'b00);
        send_fields(1'b0, $urandom, 6'd0, 12'd0, 12'd0, 2'b00, 2'b00, 2'b00, 2'b00);

        // ---- random: three idling modes, several register settings each ----
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 68 : 0;
            recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 8 : 0;
            for (int ph = 0; ph * PHASE_ITEMS < MODE_ITEMS; ph++)
            begin
                case ($urandom_range(0, 9))
                    0:       c = 13'd1;
                    1:       c = 13'd0;
                    2:       c = 13'd1024;
                    3:       c = 13'h1FFF;
                    4:       c = 13'($urandom_range(9, 1100));
                    default: c = 13'($urandom_range(2, 8));
                endcase
                case ($urandom_range(0, 9))
                    0:       r = 13'd1;
                    1:       r = 13'd0;
                    2:       r = 13'd1024;
                    3:       r = 13'd2047;
                    default: r = 13'($urandom_range(1, 5));
                endcase
                case ($urandom_range(0, 9))
                    0:       d = 13'd0;
                    1:       d = 13'd1;
                    2:       d = 13'd4096;
                    3:       d = 13'h1FFF;
                    4:       d = 13'($urandom_range(0, 8191));
                    default: d = 13'($urandom_range(4, 40));
                endcase
                write_config(c, r, d, 1'b0);
                random_burst(PHASE_ITEMS);
            end
        end

        // ---- wind-down ----
        s_axis_tvalid <= 1'b0;
        for (int w = 0; w < 5000 && sb.pending.size() != 0; w++)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d pixel writes never arrived", $time, sb.pending.size());
            sb.errors += sb.pending.size();
        end

        $display("Sent %0d pixels through %0d register writes; %0d segment ends seen.",
                 pixels_in, reg_writes, sb.lasts);
        $display("Checked %0d pixel writes, %0d inside the image, %0d mismatches.",
                 sb.checked, sb.hits, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
